// File: hdl/tch_pkg.sv
// Shared types and constants for the tilt compensated heading block.
`timescale 1ns / 1ps
`default_nettype none
package tch_pkg;
   localparam int TableLen = 24;
   localparam int AngleW = 26;
   localparam logic signed [AngleW-1:0] ATAN_TABLE [TableLen] = '{
      26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945, 26'sd234379, 26'sd117304,
      26'sd58666, 26'sd29335, 26'sd14668, 26'sd7334, 26'sd3667, 26'sd1833,
      26'sd917, 26'sd458, 26'sd229, 26'sd115, 26'sd57, 26'sd29,
      26'sd14, 26'sd7, 26'sd4, 26'sd2, 26'sd1, 26'sd0
   };
   localparam int GainQ16 = 39797;
   localparam logic signed [AngleW-1:0] HALF_TURN_Q16 = 26'sd11796480;
   localparam logic signed [16:0] HEADING_LIMIT = 17'sd23040;

   typedef logic signed [15:0] sample_type;
   typedef struct packed {
      sample_type x;
      sample_type y;
      sample_type z;
   } vec3_type;
endpackage
`default_nettype wire

// File: hdl/tch_if.sv
// Request and response channel interfaces of the heading block.
`timescale 1ns / 1ps
`default_nettype none
interface tch_req_if;
   logic valid;
   logic ready;
   tch_pkg::sample_type accel_x;
   tch_pkg::sample_type accel_y;
   tch_pkg::sample_type accel_z;
   tch_pkg::sample_type mag_x;
   tch_pkg::sample_type mag_y;
   tch_pkg::sample_type mag_z;
   modport source (output valid, accel_x, accel_y, accel_z, mag_x, mag_y, mag_z,
                   input ready);
   modport sink (input valid, accel_x, accel_y, accel_z, mag_x, mag_y, mag_z,
                 output ready);
endinterface

interface tch_rsp_if;
   logic valid;
   logic ready;
   tch_pkg::sample_type heading;
   modport source (output valid, heading, input ready);
   modport sink (input valid, heading, output ready);
endinterface
`default_nettype wire

// File: hdl/tilt_compensated_heading.sv
// Tilt compensated compass heading: squares, root, CORDIC angles, rotation, heading.
// N below is the number of CORDIC iterations.
// Throughput: one word per cycle; the whole pipeline advances unless the output is stalled.
// Stages: 1 squaring, 32 root digits, N+1 tilt atan2, N+1 sin/cos, 3 multiply,
// N+1 heading atan2, 1 output rounding.
// Reset clears the valid bits only; data registers are not reset.
`timescale 1ns / 1ps
`default_nettype none
module tilt_compensated_heading #(
   parameter int CORDIC_ITERATIONS = 16
) (
   input  logic            clock,
   input  logic            reset,
   tch_req_if.sink         req_chan,
   tch_rsp_if.source       rsp_chan
);
   import tch_pkg::*;

   localparam int Iters = (CORDIC_ITERATIONS > TableLen) ? TableLen : CORDIC_ITERATIONS;
   localparam int SqrtSteps = 32;
   localparam int TiltW = 40;
   localparam int RotW = 20;
   localparam int ProdW = 36;
   localparam int HW = 58;
   localparam int VW = 60;
   localparam int Lat = 3 * Iters + 40;
   localparam int TiltBase = SqrtSteps + 1;
   localparam int RotBase = TiltBase + Iters + 1;
   localparam int MulBase = RotBase + Iters + 1;
   localparam int HeadBase = MulBase + 3;

   typedef struct packed {
      sample_type ax;
      sample_type ay;
      vec3_type   mag;
   } tilt_type;

   logic en;
   logic [Lat-1:0] vld_ff, vld_in;

   assign en = !rsp_chan.valid || rsp_chan.ready;
   assign req_chan.ready = en;
   assign vld_in = {vld_ff[Lat-2:0], req_chan.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   // squares and digit-by-digit square root
   logic [34:0] sq_rem_ff  [2][SqrtSteps+1];
   logic [31:0] sq_root_ff [2][SqrtSteps+1];
   logic [31:0] sq_rad_ff  [2][SqrtSteps+1];
   tilt_type    sq_pl_ff   [SqrtSteps+1];
   logic signed [31:0] ax2, ay2, az2;

   assign ax2 = req_chan.accel_x * req_chan.accel_x;
   assign ay2 = req_chan.accel_y * req_chan.accel_y;
   assign az2 = req_chan.accel_z * req_chan.accel_z;

   always_ff @(posedge clock) begin
      if (en) begin
         sq_rad_ff[0][0]  <= 32'(ay2) + 32'(az2);
         sq_rad_ff[1][0]  <= 32'(ax2) + 32'(az2);
         sq_rem_ff[0][0]  <= '0;
         sq_rem_ff[1][0]  <= '0;
         sq_root_ff[0][0] <= '0;
         sq_root_ff[1][0] <= '0;
         sq_pl_ff[0] <= '{ax: req_chan.accel_x, ay: req_chan.accel_y,
                          mag: '{x: req_chan.mag_x, y: req_chan.mag_y, z: req_chan.mag_z}};
      end
   end

   for (genvar k = 0; k < SqrtSteps; k++) begin : g_sqrt
      always_ff @(posedge clock) begin
         if (en) begin
            sq_pl_ff[k+1] <= sq_pl_ff[k];
         end
      end
      for (genvar l = 0; l < 2; l++) begin : g_lane
         logic [34:0] cat, trial;
         logic        fit;
         assign cat   = {sq_rem_ff[l][k][32:0], sq_rad_ff[l][k][31:30]};
         assign trial = {1'b0, sq_root_ff[l][k], 2'b01};
         assign fit   = cat >= trial;
         always_ff @(posedge clock) begin
            if (en) begin
               sq_rem_ff[l][k+1]  <= fit ? cat - trial : cat;
               sq_root_ff[l][k+1] <= {sq_root_ff[l][k][30:0], fit};
               sq_rad_ff[l][k+1]  <= {sq_rad_ff[l][k][29:0], 2'b00};
            end
         end
      end
   end

   // pitch (lane 0) and roll (lane 1) by vectoring CORDIC
   logic signed [TiltW-1:0]  tv_x_ff [2][Iters+1];
   logic signed [TiltW-1:0]  tv_y_ff [2][Iters+1];
   logic signed [AngleW-1:0] tv_z_ff [2][Iters+1];
   logic                     tv_zero_ff [2][Iters+1];
   vec3_type                 tv_mag_ff [Iters+1];
   sample_type               tv_num [2];

   assign tv_num[0] = sq_pl_ff[SqrtSteps].ax;
   assign tv_num[1] = sq_pl_ff[SqrtSteps].ay;

   always_ff @(posedge clock) begin
      if (en) begin
         tv_mag_ff[0] <= sq_pl_ff[SqrtSteps].mag;
      end
   end

   for (genvar l = 0; l < 2; l++) begin : g_tilt_load
      always_ff @(posedge clock) begin
         if (en) begin
            tv_x_ff[l][0]    <= TiltW'({1'b0, sq_root_ff[l][SqrtSteps]});
            tv_y_ff[l][0]    <= TiltW'(tv_num[l]) <<< 16;
            tv_z_ff[l][0]    <= '0;
            tv_zero_ff[l][0] <= (sq_root_ff[l][SqrtSteps] == '0) && (tv_num[l] == '0);
         end
      end
   end

   for (genvar i = 0; i < Iters; i++) begin : g_tilt
      always_ff @(posedge clock) begin
         if (en) begin
            tv_mag_ff[i+1] <= tv_mag_ff[i];
         end
      end
      for (genvar l = 0; l < 2; l++) begin : g_lane
         always_ff @(posedge clock) begin
            if (en) begin
               tv_zero_ff[l][i+1] <= tv_zero_ff[l][i];
               if (!tv_y_ff[l][i][TiltW-1]) begin
                  tv_x_ff[l][i+1] <= tv_x_ff[l][i] + (tv_y_ff[l][i] >>> i);
                  tv_y_ff[l][i+1] <= tv_y_ff[l][i] - (tv_x_ff[l][i] >>> i);
                  tv_z_ff[l][i+1] <= tv_z_ff[l][i] + ATAN_TABLE[i];
               end else begin
                  tv_x_ff[l][i+1] <= tv_x_ff[l][i] - (tv_y_ff[l][i] >>> i);
                  tv_y_ff[l][i+1] <= tv_y_ff[l][i] + (tv_x_ff[l][i] >>> i);
                  tv_z_ff[l][i+1] <= tv_z_ff[l][i] - ATAN_TABLE[i];
               end
            end
         end
      end
   end

   // cosine and sine of pitch and roll by rotation CORDIC
   logic signed [RotW-1:0]   rt_x_ff [2][Iters+1];
   logic signed [RotW-1:0]   rt_y_ff [2][Iters+1];
   logic signed [AngleW-1:0] rt_z_ff [2][Iters+1];
   vec3_type                 rt_mag_ff [Iters+1];

   always_ff @(posedge clock) begin
      if (en) begin
         rt_mag_ff[0] <= tv_mag_ff[Iters];
      end
   end

   for (genvar l = 0; l < 2; l++) begin : g_rot_load
      always_ff @(posedge clock) begin
         if (en) begin
            rt_x_ff[l][0] <= RotW'(GainQ16);
            rt_y_ff[l][0] <= '0;
            rt_z_ff[l][0] <= tv_zero_ff[l][Iters] ? '0 : tv_z_ff[l][Iters];
         end
      end
   end

   for (genvar i = 0; i < Iters; i++) begin : g_rot
      always_ff @(posedge clock) begin
         if (en) begin
            rt_mag_ff[i+1] <= rt_mag_ff[i];
         end
      end
      for (genvar l = 0; l < 2; l++) begin : g_lane
         always_ff @(posedge clock) begin
            if (en) begin
               if (!rt_z_ff[l][i][AngleW-1]) begin
                  rt_x_ff[l][i+1] <= rt_x_ff[l][i] - (rt_y_ff[l][i] >>> i);
                  rt_y_ff[l][i+1] <= rt_y_ff[l][i] + (rt_x_ff[l][i] >>> i);
                  rt_z_ff[l][i+1] <= rt_z_ff[l][i] - ATAN_TABLE[i];
               end else begin
                  rt_x_ff[l][i+1] <= rt_x_ff[l][i] + (rt_y_ff[l][i] >>> i);
                  rt_y_ff[l][i+1] <= rt_y_ff[l][i] - (rt_x_ff[l][i] >>> i);
                  rt_z_ff[l][i+1] <= rt_z_ff[l][i] + ATAN_TABLE[i];
               end
            end
         end
      end
   end

   // tilt compensation products
   logic signed [RotW-1:0]  cp, sp, cr, sr, m1_sp_ff, m1_sr_ff;
   logic signed [ProdW-1:0] m1_mycr_ff, m1_mxsr_ff, m1_mzcp_ff, m1_mxcp_ff, m1_mzsp_ff;
   logic signed [HW-1:0]    m2_hyb_ff, m2_q1_ff, m2_q2_ff, m2_hx_ff, m3_hy_ff, m3_hx_ff;

   assign cp = rt_x_ff[0][Iters];
   assign sp = rt_y_ff[0][Iters];
   assign cr = rt_x_ff[1][Iters];
   assign sr = rt_y_ff[1][Iters];

   always_ff @(posedge clock) begin
      if (en) begin
         m1_mycr_ff <= rt_mag_ff[Iters].y * cr;
         m1_mxsr_ff <= rt_mag_ff[Iters].x * sr;
         m1_mzcp_ff <= rt_mag_ff[Iters].z * cp;
         m1_mxcp_ff <= rt_mag_ff[Iters].x * cp;
         m1_mzsp_ff <= rt_mag_ff[Iters].z * sp;
         m1_sp_ff   <= sp;
         m1_sr_ff   <= sr;
         m2_hyb_ff  <= HW'(m1_mycr_ff) <<< 16;
         m2_q1_ff   <= HW'(m1_mxsr_ff) * HW'(m1_sp_ff);
         m2_q2_ff   <= HW'(m1_mzcp_ff) * HW'(m1_sr_ff);
         m2_hx_ff   <= (HW'(m1_mxcp_ff) + HW'(m1_mzsp_ff)) <<< 16;
         m3_hy_ff   <= m2_hyb_ff + m2_q1_ff - m2_q2_ff;
         m3_hx_ff   <= m2_hx_ff;
      end
   end

   // heading by vectoring CORDIC with half-turn prerotation
   logic signed [VW-1:0]     hv_x_ff [Iters+1];
   logic signed [VW-1:0]     hv_y_ff [Iters+1];
   logic signed [AngleW-1:0] hv_z_ff [Iters+1];
   logic                     hv_zero_ff [Iters+1];

   always_ff @(posedge clock) begin
      if (en) begin
         hv_zero_ff[0] <= (m3_hx_ff == '0) && (m3_hy_ff == '0);
         if (m3_hx_ff[HW-1]) begin
            hv_x_ff[0] <= -VW'(m3_hx_ff);
            hv_y_ff[0] <= -VW'(m3_hy_ff);
            hv_z_ff[0] <= m3_hy_ff[HW-1] ? -HALF_TURN_Q16 : HALF_TURN_Q16;
         end else begin
            hv_x_ff[0] <= VW'(m3_hx_ff);
            hv_y_ff[0] <= VW'(m3_hy_ff);
            hv_z_ff[0] <= '0;
         end
      end
   end

   for (genvar i = 0; i < Iters; i++) begin : g_head
      always_ff @(posedge clock) begin
         if (en) begin
            hv_zero_ff[i+1] <= hv_zero_ff[i];
            if (!hv_y_ff[i][VW-1]) begin
               hv_x_ff[i+1] <= hv_x_ff[i] + (hv_y_ff[i] >>> i);
               hv_y_ff[i+1] <= hv_y_ff[i] - (hv_x_ff[i] >>> i);
               hv_z_ff[i+1] <= hv_z_ff[i] + ATAN_TABLE[i];
            end else begin
               hv_x_ff[i+1] <= hv_x_ff[i] - (hv_y_ff[i] >>> i);
               hv_y_ff[i+1] <= hv_y_ff[i] + (hv_x_ff[i] >>> i);
               hv_z_ff[i+1] <= hv_z_ff[i] - ATAN_TABLE[i];
            end
         end
      end
   end

   // round to 1/128 degree and saturate
   logic signed [AngleW-1:0] deg, deg_rnd;
   logic signed [16:0]       h_wide;
   sample_type               heading_ff, heading_in;

   assign deg     = hv_zero_ff[Iters] ? '0 : hv_z_ff[Iters];
   assign deg_rnd = (deg + AngleW'(256)) >>> 9;
   assign h_wide  = deg_rnd[16:0];

   always_comb begin
      if (h_wide > HEADING_LIMIT) begin
         heading_in = 16'(HEADING_LIMIT);
      end else if (h_wide < -HEADING_LIMIT) begin
         heading_in = 16'(-HEADING_LIMIT);
      end else begin
         heading_in = h_wide[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         heading_ff <= heading_in;
      end
   end

   assign rsp_chan.valid   = vld_ff[Lat-1];
   assign rsp_chan.heading = heading_ff;

   a_heading_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.heading <= 16'sd23040 && rsp_chan.heading >= -16'sd23040))
      else $error("heading out of range");

   a_pitch_x_pos: assert property (@(posedge clock) disable iff (reset)
      vld_ff[RotBase-1] |-> !tv_x_ff[0][Iters][TiltW-1])
      else $error("pitch vector x negative");

   a_roll_x_pos: assert property (@(posedge clock) disable iff (reset)
      vld_ff[RotBase-1] |-> !tv_x_ff[1][Iters][TiltW-1])
      else $error("roll vector x negative");

   a_head_x_pos: assert property (@(posedge clock) disable iff (reset)
      vld_ff[HeadBase] |-> !hv_x_ff[0][VW-1])
      else $error("heading prerotation left x negative");

   a_root_zero: assert property (@(posedge clock) disable iff (reset)
      vld_ff[TiltBase] && tv_zero_ff[0][0] |-> tv_x_ff[0][0] == '0)
      else $error("pitch zero flag with nonzero root");
endmodule
`default_nettype wire
